/* sv/sha256_message_hasher_assert.svh */
// ----------------------------------------------------------------------------
// SHA-256 message hasher assertion macros
// Same-cycle-implication and next-cycle-implication property wrappers.
// ----------------------------------------------------------------------------
`ifndef SHA256_MESSAGE_HASHER_ASSERT_SVH
`define SHA256_MESSAGE_HASHER_ASSERT_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define SMH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off during reset
`define SMH_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/smh_pkg.sv */
// ----------------------------------------------------------------------------
// SHA-256 message hasher package
// Round constants, initial hash values, round functions and datapath control.
// ----------------------------------------------------------------------------
package smh_pkg;

  localparam int unsigned HashDepth = 8;
  localparam int unsigned HashAw    = 3;
  localparam int unsigned WordW     = 32;
  localparam int unsigned WinW      = 512;
  localparam int unsigned BlkCntW   = 55;

  localparam logic [7:0] PadByte  = 8'h80;
  localparam logic [5:0] LenStart = 6'd56;
  localparam logic [5:0] LastByte = 6'd63;

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] HashIv [HashDepth] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef struct packed {
    logic       push;
    logic       load;
    logic       rotate;
    logic       round;
    logic [5:0] rnd;
  } smh_dp_ctl_t;

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

  function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
                                         input logic [31:0] g);
    return (e & f) ^ (~e & g);
  endfunction

  function automatic logic [31:0] majority(input logic [31:0] a, input logic [31:0] b,
                                           input logic [31:0] c);
    return (a & b) ^ (a & c) ^ (b & c);
  endfunction

endpackage

/* sv/sha256_message_hasher.sv */
// ----------------------------------------------------------------------------
// SHA-256 message hasher
// Byte-wide message in, eight 32-bit digest words out per message.
//
//   channel | handshake                   | payload
//   in      | in_valid_i / in_ready_o     | msg_byte_i, has_byte_i, is_last_i
//   out     | out_valid_o / out_ready_i   | digest_word_o, word_index_o, last_word_o
//
// Byte items are taken back to back; the 64th byte of a block starts a
// compression (8 hash RAM reads, 64 rounds, 8 read-modify-writes of the RAM).
// A last item adds one padding byte a cycle plus one or two compressions,
// then the digest words are read out in turn through the hash RAM read port.
// Reset loads the initial hash through per-entry valid bits; no clear pass.
// A stalled output holds its word; input is taken again once digest reads end.
// ----------------------------------------------------------------------------
module sha256_message_hasher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  msg_byte_i,
  input  logic        has_byte_i,
  input  logic        is_last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);
  import smh_pkg::*;

  typedef enum logic [5:0] {
    StIdle   = 6'b000001,
    StLoad   = 6'b000010,
    StRound  = 6'b000100,
    StUpdate = 6'b001000,
    StPad    = 6'b010000,
    StOut    = 6'b100000
  } state_e;

  state_e              state_q, state_d;
  logic [3:0]          cnt_q, cnt_d;
  logic [5:0]          rnd_q, rnd_d;
  logic [5:0]          count_q, count_d;
  logic [BlkCntW-1:0]  blk_q, blk_d;
  logic [63:0]         len_q, len_d;
  logic                pad_act_q, pad_act_d;
  logic                pad_first_q, pad_first_d;
  logic                len_ph_q, len_ph_d;
  logic                pend_last_q, pend_last_d;
  logic [HashDepth-1:0] hvld_q, hvld_d;
  logic [HashAw-1:0]   rd_idx_q;
  logic                rd_iv_q;
  logic                ld_rd_q, up_rd_q, out_rd_q;
  logic                out_valid_q;
  logic [31:0]         out_word_q;
  logic [2:0]          out_idx_q;
  logic                out_last_q;

  logic                in_fire, rd_issue;
  logic [7:0]          push_byte;
  logic [31:0]         ram_rdata, hash_rd, rv_head;
  smh_dp_ctl_t         ctl;

  assign in_ready_o = (state_q == StIdle);
  assign in_fire    = in_valid_i && in_ready_o;
  assign hash_rd    = rd_iv_q ? HashIv[rd_idx_q] : ram_rdata;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    rnd_d       = rnd_q;
    count_d     = count_q;
    blk_d       = blk_q;
    len_d       = len_q;
    pad_act_d   = pad_act_q;
    pad_first_d = pad_first_q;
    len_ph_d    = len_ph_q;
    pend_last_d = pend_last_q;
    hvld_d      = hvld_q;
    rd_issue    = 1'b0;
    push_byte   = msg_byte_i;
    ctl         = '0;
    ctl.rnd     = rnd_q;
    ctl.load    = ld_rd_q;
    ctl.rotate  = up_rd_q;

    if (up_rd_q) begin
      hvld_d[rd_idx_q] = 1'b1;
    end

    case (state_q)
      StIdle: begin
        if (in_fire) begin
          if (has_byte_i) begin
            ctl.push = 1'b1;
            count_d  = count_q + 6'd1;
          end
          if (has_byte_i && count_q == LastByte) begin
            blk_d       = blk_q + BlkCntW'(1);
            pend_last_d = is_last_i;
            state_d     = StLoad;
            cnt_d       = '0;
          end else if (is_last_i) begin
            state_d     = StPad;
            pad_act_d   = 1'b1;
            pad_first_d = 1'b1;
            len_ph_d    = 1'b0;
            len_d       = {blk_d, count_d, 3'b000};
          end
        end
      end
      StPad: begin
        ctl.push = 1'b1;
        count_d  = count_q + 6'd1;
        if (pad_first_q) begin
          push_byte   = PadByte;
          pad_first_d = 1'b0;
        end else if (len_ph_q || count_q == LenStart) begin
          push_byte = len_q[63:56];
          len_d     = {len_q[55:0], 8'h00};
          len_ph_d  = 1'b1;
        end else begin
          push_byte = 8'h00;
        end
        if (count_q == LastByte) begin
          state_d = StLoad;
          cnt_d   = '0;
        end
      end
      StLoad: begin
        if (!cnt_q[3]) begin
          rd_issue = 1'b1;
          cnt_d    = cnt_q + 4'd1;
        end else if (ld_rd_q) begin
          state_d = StRound;
          rnd_d   = '0;
        end
      end
      StRound: begin
        ctl.round = 1'b1;
        rnd_d     = rnd_q + 6'd1;
        if (rnd_q == LastByte) begin
          state_d = StUpdate;
          cnt_d   = '0;
        end
      end
      StUpdate: begin
        if (!cnt_q[3]) begin
          rd_issue = 1'b1;
          cnt_d    = cnt_q + 4'd1;
        end else if (up_rd_q) begin
          cnt_d = '0;
          if (pad_act_q && len_ph_q) begin
            state_d = StOut;
          end else if (pad_act_q) begin
            state_d = StPad;
          end else if (pend_last_q) begin
            state_d     = StPad;
            pend_last_d = 1'b0;
            pad_act_d   = 1'b1;
            pad_first_d = 1'b1;
            len_ph_d    = 1'b0;
            len_d       = {blk_q, count_q, 3'b000};
          end else begin
            state_d = StIdle;
          end
        end
      end
      StOut: begin
        if (!cnt_q[3]) begin
          if (!out_rd_q && (!out_valid_q || out_ready_i)) begin
            rd_issue = 1'b1;
            cnt_d    = cnt_q + 4'd1;
          end
        end else begin
          state_d   = StIdle;
          hvld_d    = '0;
          blk_d     = '0;
          count_d   = '0;
          pad_act_d = 1'b0;
          len_ph_d  = 1'b0;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      rnd_q       <= '0;
      count_q     <= '0;
      blk_q       <= '0;
      pad_act_q   <= 1'b0;
      pad_first_q <= 1'b0;
      len_ph_q    <= 1'b0;
      pend_last_q <= 1'b0;
      hvld_q      <= '0;
      ld_rd_q     <= 1'b0;
      up_rd_q     <= 1'b0;
      out_rd_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rnd_q       <= rnd_d;
      count_q     <= count_d;
      blk_q       <= blk_d;
      pad_act_q   <= pad_act_d;
      pad_first_q <= pad_first_d;
      len_ph_q    <= len_ph_d;
      pend_last_q <= pend_last_d;
      hvld_q      <= hvld_d;
      ld_rd_q     <= rd_issue && (state_q == StLoad);
      up_rd_q     <= rd_issue && (state_q == StUpdate);
      out_rd_q    <= rd_issue && (state_q == StOut);
      if (out_rd_q) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    len_q <= len_d;
    if (rd_issue) begin
      rd_idx_q <= cnt_q[2:0];
      rd_iv_q  <= !hvld_q[cnt_q[2:0]];
    end
    if (out_rd_q) begin
      out_word_q <= hash_rd;
      out_idx_q  <= rd_idx_q;
      out_last_q <= (rd_idx_q == 3'd7);
    end
  end

  smh_ram #(
    .Width(WordW),
    .Depth(HashDepth)
  ) u_hash_ram (
    .clk_i  (clk_i),
    .we_i   (up_rd_q),
    .waddr_i(rd_idx_q),
    .wdata_i(hash_rd + rv_head),
    .re_i   (rd_issue),
    .raddr_i(cnt_q[2:0]),
    .rdata_o(ram_rdata)
  );

  smh_dp u_dp (
    .clk_i      (clk_i),
    .ctl_i      (ctl),
    .byte_i     (push_byte),
    .load_word_i(hash_rd),
    .rv_head_o  (rv_head)
  );

  assign out_valid_o   = out_valid_q;
  assign digest_word_o = out_word_q;
  assign word_index_o  = out_idx_q;
  assign last_word_o   = out_last_q;

endmodule

/* sv/smh_ram.sv */
// ----------------------------------------------------------------------------
// SHA-256 message hasher RAM
// Generic one-write, one-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module smh_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/smh_dp.sv */
// ----------------------------------------------------------------------------
// SHA-256 message hasher datapath
// Message schedule window and working variables with one round per cycle.
// ----------------------------------------------------------------------------
module smh_dp (
  input  logic                clk_i,
  input  smh_pkg::smh_dp_ctl_t ctl_i,
  input  logic [7:0]          byte_i,
  input  logic [31:0]         load_word_i,
  output logic [31:0]         rv_head_o
);
  import smh_pkg::*;

  logic [WinW-1:0]          win_q, win_d;
  logic [7:0][WordW-1:0]    rv_q, rv_d;
  logic [WordW-1:0]         w_cur, w_new, t1, t2, tail;

  // word 0 of the window is W[t], word 15 is W[t+15]
  assign w_cur = win_q[WinW-1 -: WordW];
  assign w_new = ssig1(win_q[WinW-1-14*WordW -: WordW]) + win_q[WinW-1-9*WordW -: WordW]
               + ssig0(win_q[WinW-1-WordW -: WordW]) + w_cur;

  assign t1 = rv_q[7] + bsig1(rv_q[4]) + choose(rv_q[4], rv_q[5], rv_q[6])
            + RoundK[ctl_i.rnd] + w_cur;
  assign t2 = bsig0(rv_q[0]) + majority(rv_q[0], rv_q[1], rv_q[2]);

  assign tail = ctl_i.load ? load_word_i : rv_q[0];

  always_comb begin
    win_d = win_q;
    rv_d  = rv_q;
    if (ctl_i.push) begin
      win_d = {win_q[WinW-9:0], byte_i};
    end else if (ctl_i.round) begin
      win_d = {win_q[WinW-WordW-1:0], w_new};
    end
    if (ctl_i.load || ctl_i.rotate) begin
      for (int i = 0; i < 7; i++) begin
        rv_d[i] = rv_q[i+1];
      end
      rv_d[7] = tail;
    end else if (ctl_i.round) begin
      rv_d[7] = rv_q[6];
      rv_d[6] = rv_q[5];
      rv_d[5] = rv_q[4];
      rv_d[4] = rv_q[3] + t1;
      rv_d[3] = rv_q[2];
      rv_d[2] = rv_q[1];
      rv_d[1] = rv_q[0];
      rv_d[0] = t1 + t2;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
    rv_q  <= rv_d;
  end

  assign rv_head_o = rv_q[0];

endmodule

/* sv/smh_chk.sv */
// ----------------------------------------------------------------------------
// SHA-256 message hasher checker
// Port-level properties of the hasher, bound to the top level.
// ----------------------------------------------------------------------------
`include "sha256_message_hasher_assert.svh"

module smh_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [7:0]  msg_byte_i,
  input logic        has_byte_i,
  input logic        is_last_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] digest_word_o,
  input logic [2:0]  word_index_o,
  input logic        last_word_o
);

  logic in_fire;
  logic in_idle_item;

  assign in_fire      = in_valid_i && in_ready_o && (msg_byte_i == msg_byte_i);
  assign in_idle_item = in_fire && !has_byte_i && !is_last_i;

  `SMH_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(digest_word_o) && $stable(word_index_o), "stalled digest word changed")
  `SMH_ASSERT_IMP(a_last_flag, out_valid_o, last_word_o == (word_index_o == 3'd7), "last_word does not match word_index 7")
  `SMH_ASSERT_NXT(a_last_busy, in_fire && is_last_i, !in_ready_o, "input still taken after a last item")
  `SMH_ASSERT_NXT(a_idle_item, in_idle_item, in_ready_o, "idle item stalled the input")

endmodule

bind sha256_message_hasher smh_chk u_smh_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .msg_byte_i   (msg_byte_i),
  .has_byte_i   (has_byte_i),
  .is_last_i    (is_last_i),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .digest_word_o(digest_word_o),
  .word_index_o (word_index_o),
  .last_word_o  (last_word_o)
);

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// SHA-256 message hasher testbench
// Streams whole messages in, at most one byte per item. Many of the
// lengths sit around the padding and block boundaries. Both channels pause at random, and
// the output side holds off once for a long stretch. A scoreboard runs its
// own SHA-256 on every accepted item and checks each digest word against it.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam bit [31:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam bit [31:0] RoundConst [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam int unsigned RandomItems = 350;
  localparam int unsigned HoldOffCycles = 500;
  localparam int unsigned DrainCycles = 200;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        fin;
  } digest_word_t;

  class sha_scoreboard;
    bit [31:0]    hash_words [8];
    bit [7:0]     blk [64];
    bit [5:0]     fill;
    bit [63:0]    bit_len;
    digest_word_t digest_q [$];
    int unsigned  errors;

    function new();
      errors = 0;
      restart();
    endfunction

    function void restart();
      hash_words = InitHash;
      fill = '0;
      bit_len = '0;
    endfunction

    function int unsigned pending();
      return digest_q.size();
    endfunction

    function bit [31:0] rotr(input bit [31:0] x, input int unsigned n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function void compress();
      bit [31:0] w [64];
      bit [31:0] v [8];
      bit [31:0] s0, s1, t1, t2;
      for (int r = 0; r < 16; r++) begin
        w[r] = {blk[4*r], blk[4*r+1], blk[4*r+2], blk[4*r+3]};
      end
      for (int r = 16; r < 64; r++) begin
        s0 = rotr(w[r-15], 7) ^ rotr(w[r-15], 18) ^ (w[r-15] >> 3);
        s1 = rotr(w[r-2], 17) ^ rotr(w[r-2], 19) ^ (w[r-2] >> 10);
        w[r] = w[r-16] + s0 + w[r-7] + s1;
      end
      v = hash_words;
      for (int r = 0; r < 64; r++) begin
        t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundConst[r] + w[r];
        t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6];
        v[6] = v[5];
        v[5] = v[4];
        v[4] = v[3] + t1;
        v[3] = v[2];
        v[2] = v[1];
        v[1] = v[0];
        v[0] = t1 + t2;
      end
      for (int k = 0; k < 8; k++) begin
        hash_words[k] = hash_words[k] + v[k];
      end
    endfunction

    function void note_item(input bit [7:0] b, input bit has, input bit fin);
      bit [63:0]    total;
      int unsigned  pos;
      digest_word_t dw;
      if (has) begin
        blk[fill] = b;
        fill = fill + 6'd1;
        if (fill == 6'd0) begin
          compress();
          bit_len = bit_len + 64'd512;
        end
      end
      if (!fin) return;
      total = bit_len + (64'(fill) << 3);
      pos = fill;
      blk[pos] = 8'h80;
      pos++;
      if (pos > 56) begin
        while (pos < 64) begin
          blk[pos] = 8'h00;
          pos++;
        end
        compress();
        pos = 0;
      end
      while (pos < 56) begin
        blk[pos] = 8'h00;
        pos++;
      end
      for (int k = 0; k < 8; k++) begin
        blk[63-k] = total[8*k +: 8];
      end
      compress();
      for (int k = 0; k < 8; k++) begin
        dw.word = hash_words[k];
        dw.index = 3'(k);
        dw.fin = (k == 7);
        digest_q.push_back(dw);
      end
      restart();
    endfunction

    function void check_word(input logic [31:0] word, input logic [2:0] index,
                             input logic fin);
      digest_word_t exp_w;
      if (digest_q.size() == 0) begin
        $display("%0t: unexpected digest word %h index %0d", $time, word, index);
        errors++;
        return;
      end
      exp_w = digest_q.pop_front();
      if (word !== exp_w.word) begin
        $display("%0t: digest_word expected %h actual %h", $time, exp_w.word, word);
        errors++;
      end
      if (index !== exp_w.index) begin
        $display("%0t: word_index expected %0d actual %0d", $time, exp_w.index, index);
        errors++;
      end
      if (fin !== exp_w.fin) begin
        $display("%0t: last_word expected %0b actual %0b", $time, exp_w.fin, fin);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  msg_byte;
  logic        has_byte;
  logic        is_last;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  sha_scoreboard sb = new();

  bit          random_phase = 1'b0;
  int unsigned payload_items = 0;
  int unsigned burst_left = 0;

  sha256_message_hasher u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .msg_byte_i    (msg_byte),
    .has_byte_i    (has_byte),
    .is_last_i     (is_last),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .digest_word_o (digest_word),
    .word_index_o  (word_index),
    .last_word_o   (last_word)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic pace_sender();
    int unsigned gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 8);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                : $urandom_range(0, 16);
    end
  endtask

  task automatic push_item(input logic [7:0] b, input logic has, input logic fin);
    @(negedge clk);
    in_valid <= 1'b1;
    msg_byte <= b;
    has_byte <= has;
    is_last  <= fin;
    do @(posedge clk); while (!in_ready);
    sb.note_item(b, has, fin);
    if (has || fin) payload_items++;
    pace_sender();
  endtask

  task automatic send_message(input int unsigned len);
    bit tail;
    tail = (len != 0) && ($urandom_range(0, 1) == 1);
    for (int unsigned k = 0; k < len - tail; k++) begin
      if ($urandom_range(0, 19) == 0) push_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      push_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
    end
    push_item(8'($urandom_range(0, 255)), tail, 1'b1);
  endtask

  function automatic int unsigned pick_length();
    int unsigned sel;
    int unsigned edges [8] = '{55, 56, 57, 63, 64, 65, 119, 120};
    sel = $urandom_range(0, 9);
    if (sel < 3) return $urandom_range(0, 8);
    if (sel < 6) return edges[$urandom_range(0, 7)];
    return $urandom_range(0, 70);
  endfunction

  // receiver: pattern-driven stalls, one long hold-off once results are due
  initial begin
    int unsigned hold_left;
    int unsigned pat_left;
    bit [31:0]   stall_pat;
    bit [4:0]    pat_pos;
    bit          held_off;
    hold_left = 0;
    pat_left = 0;
    stall_pat = '1;
    pat_pos = '0;
    held_off = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!held_off && random_phase && sb.pending() != 0) begin
        held_off = 1'b1;
        hold_left = HoldOffCycles - 1;
        out_ready <= 1'b0;
      end else begin
        if (pat_left == 0) begin
          pat_left = $urandom_range(16, 64);
          stall_pat = ($urandom_range(0, 3) == 0) ? '1 : ($urandom | 32'h1);
        end
        pat_left--;
        out_ready <= stall_pat[pat_pos];
        pat_pos++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_word(digest_word, word_index, last_word);
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    msg_byte = '0;
    has_byte = 1'b0;
    is_last = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    push_item(8'h5a, 1'b0, 1'b0);
    push_item(8'hff, 1'b0, 1'b1);
    push_item(8'h61, 1'b1, 1'b0);
    push_item(8'h62, 1'b1, 1'b0);
    push_item(8'h63, 1'b1, 1'b1);
    push_item(8'h00, 1'b1, 1'b0);
    push_item(8'ha5, 1'b0, 1'b0);
    push_item(8'hff, 1'b1, 1'b0);
    push_item(8'h3c, 1'b0, 1'b1);
    push_item(8'hff, 1'b1, 1'b1);
    push_item(8'h00, 1'b1, 1'b1);
    push_item(8'h00, 1'b0, 1'b1);

    random_phase = 1'b1;
    payload_items = 0;
    while (payload_items < RandomItems) begin
      send_message(pick_length());
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
